@@ rtl/esdm_pkg.sv @@
// Shared types and constants of the encoder speed and distance meter
`timescale 1ns / 1ps

package esdm_pkg;

  // serial multiply/divide unit: a * b / c
  localparam int unsigned OP_A_W = 33;
  localparam int unsigned OP_B_W = 24;
  localparam int unsigned OP_C_W = 24;
  localparam int unsigned PROD_W = OP_A_W + OP_B_W;
  localparam int unsigned CNT_W  = 6;
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(OP_B_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  localparam int unsigned CIRC_W = 18;
  localparam int unsigned RG_W   = 24;
  localparam int unsigned DIST_W = 48;

  // item kinds
  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ARM   = 3'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 27;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAM     = 8'd3;

  localparam logic [26:0] CLOCK_HZ_RST = 27'd1000000;

  localparam logic [OP_B_W-1:0] CIRC_NUM    = 24'd314;
  localparam logic [OP_C_W-1:0] CIRC_DEN    = 24'd100;
  localparam logic [OP_B_W-1:0] SEC_PER_MIN = 24'd60;
  localparam logic [DIST_W-1:0] MAX48       = {DIST_W{1'b1}};

  typedef struct packed {
    logic [26:0]     clock_hz;
    logic [15:0]     wheel_diameter_mm;
    logic [RG_W-1:0] rg;               // pulses * gear, never zero
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [OP_A_W-1:0] a;
    logic [OP_B_W-1:0] b;
    logic [OP_C_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
  } md_rsp_t;

endpackage

@@ rtl/esdm_if.sv @@
// Handshake channels of the encoder speed and distance meter
`timescale 1ns / 1ps

interface esdm_in_if import esdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [15:0]       edge_period;
  logic [31:0]       target_mm;

  modport source (output valid, output kind, output edge_period, output target_mm,
                  input ready);
  modport sink (input valid, input kind, input edge_period, input target_mm,
                output ready);
endinterface

interface esdm_out_if import esdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [31:0]       pulse_count;
  logic [31:0]       error_count;
  logic [15:0]       last_period;
  logic [32:0]       speed_rpm;
  logic [44:0]       speed_mm_per_s;
  logic [DIST_W-1:0] distance_mm;
  logic              target_reached;

  modport source (output valid, output pulse_count, output error_count,
                  output last_period, output speed_rpm, output speed_mm_per_s,
                  output distance_mm, output target_reached, input ready);
  modport sink (input valid, input pulse_count, input error_count,
                input last_period, input speed_rpm, input speed_mm_per_s,
                input distance_mm, input target_reached, output ready);
endinterface

interface esdm_cfg_if import esdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/esdm_cfg_regs.sv @@
// Configuration registers and derived resolution term
`timescale 1ns / 1ps

module esdm_cfg_regs import esdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  esdm_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  logic [26:0]     clock_hz_q;
  logic [15:0]     ppr_q;
  logic [7:0]      gear_q;
  logic [15:0]     diam_q;
  logic [RG_W-1:0] rg_q, rg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    rg_d = RG_W'(ppr_q) * RG_W'(gear_q);
    if (rg_d == '0) begin
      rg_d = RG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
      ppr_q      <= 16'd1;
      gear_q     <= 8'd1;
      diam_q     <= 16'd1;
      rg_q       <= RG_W'(1);
    end else begin
      rg_q <= rg_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_CLOCK_HZ:       clock_hz_q <= cfg_i.data[26:0];
          REG_PULSES_PER_REV: ppr_q      <= cfg_i.data[15:0];
          REG_GEAR_RATIO:     gear_q     <= cfg_i.data[7:0];
          REG_WHEEL_DIAM:     diam_q     <= cfg_i.data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.clock_hz          = clock_hz_q;
  assign cfg_o.wheel_diameter_mm = diam_q;
  assign cfg_o.rg                = rg_q;

endmodule

@@ rtl/esdm_muldiv.sv @@
// Bit-serial a*b/c unit: shift-add multiply then restoring divide
`timescale 1ns / 1ps

module esdm_muldiv import esdm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [PROD_W-1:0] a_q, a_d;
  logic [OP_B_W-1:0] b_q, b_d;
  logic [OP_C_W-1:0] c_q, c_d;
  logic [PROD_W-1:0] acc_q, acc_d;   // product, then dividend/quotient
  logic [OP_C_W-1:0] rem_q, rem_d;
  logic [OP_C_W:0]   trial;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    trial   = {rem_q, acc_q[PROD_W-1]};
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          a_d     = PROD_W'(req_i.a);
          b_d     = req_i.b;
          c_d     = req_i.c;
          acc_d   = '0;
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d   = {a_q[PROD_W-2:0], 1'b0};
        b_d   = {1'b0, b_q[OP_B_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        // one quotient bit per cycle, shifted into the bottom of acc
        if (trial >= {1'b0, c_q}) begin
          rem_d = OP_C_W'(trial - {1'b0, c_q});
          acc_d = {acc_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = trial[OP_C_W-1:0];
          acc_d = {acc_q[PROD_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> phase_q == PH_IDLE)
    else $error("muldiv started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("muldiv done longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIV && c_q != '0) |-> rem_q < c_q)
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == PH_IDLE && $past(phase_q) == PH_DIV)
    else $error("muldiv done without a divide pass");

endmodule

@@ rtl/encoder_speed_distance_meter.sv @@
// Top level: encoder counters, target logic and speed/distance sequencer
`timescale 1ns / 1ps

// Wheel encoder meter. Each input transfer is an edge (with its period), a
// capture error, a clear, a target arm, a read or a spare kind, and gives
// exactly one status result. Counters and the stored period update in the
// cycle of the transfer; circumference, rpm, mm/s and distance are then
// worked out in turn on one shared bit-serial multiply/divide unit, one pass
// each, with a pass for the rpm factor before rpm. When the stored period is
// zero the factor and rpm passes are skipped, and an arm with a nonzero target
// and circumference adds one pass for the target count. That unit sets the
// rate: one item at a time, the next transfer taken once the result has gone
// to the output register, which may still be waiting for the sink.
module encoder_speed_distance_meter import esdm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  esdm_in_if.sink    in_i,
  esdm_out_if.source out_o,
  esdm_cfg_if.sink   cfg_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CIRC = 3'd1;
  localparam logic [2:0] ST_TGT  = 3'd2;
  localparam logic [2:0] ST_FACT = 3'd3;
  localparam logic [2:0] ST_RPM  = 3'd4;
  localparam logic [2:0] ST_MMPS = 3'd5;
  localparam logic [2:0] ST_DIST = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  cfg_t    cfg;
  md_req_t md_req;
  md_rsp_t md_rsp;

  logic [2:0]        st_q, st_d;
  logic              go_q, go_d;
  logic [31:0]       edge_cnt_q, edge_cnt_d;
  logic [31:0]       err_cnt_q, err_cnt_d;
  logic [15:0]       period_q, period_d;
  logic [DIST_W-1:0] target_q, target_d;
  logic              fired_q, fired_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [31:0]       tmm_q, tmm_d;
  logic [CIRC_W-1:0] circ_q, circ_d;
  logic [32:0]       fact_q, fact_d;
  logic [32:0]       rpm_q, rpm_d;
  logic [44:0]       mmps_q, mmps_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [31:0]       edge_inc;
  logic              in_xfer;
  logic              out_load;

  logic              out_valid_q, out_valid_d;
  logic [31:0]       o_pulse_q, o_err_q;
  logic [15:0]       o_period_q;
  logic [32:0]       o_rpm_q;
  logic [44:0]       o_mmps_q;
  logic [DIST_W-1:0] o_dist_q;
  logic              o_fired_q;

  esdm_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  esdm_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_xfer    = in_i.valid && (st_q == ST_IDLE);
  assign edge_inc   = edge_cnt_q + 32'd1;
  assign out_load   = (st_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // operands of the shared unit follow the sequencer state
  always_comb begin
    md_req.start = go_q;
    md_req.a     = '0;
    md_req.b     = '0;
    md_req.c     = '0;
    case (st_q)
      ST_CIRC: begin
        md_req.a = OP_A_W'(cfg.wheel_diameter_mm);
        md_req.b = CIRC_NUM;
        md_req.c = CIRC_DEN;
      end
      ST_TGT: begin
        md_req.a = OP_A_W'(tmm_q);
        md_req.b = cfg.rg;
        md_req.c = OP_C_W'(circ_q);
      end
      ST_FACT: begin
        md_req.a = OP_A_W'(cfg.clock_hz);
        md_req.b = SEC_PER_MIN;
        md_req.c = cfg.rg;
      end
      ST_RPM: begin
        md_req.a = fact_q;
        md_req.b = OP_B_W'(1);
        md_req.c = OP_C_W'(period_q);
      end
      ST_MMPS: begin
        md_req.a = rpm_q;
        md_req.b = OP_B_W'(circ_q);
        md_req.c = SEC_PER_MIN;
      end
      ST_DIST: begin
        md_req.a = OP_A_W'(edge_cnt_q);
        md_req.b = OP_B_W'(circ_q);
        md_req.c = cfg.rg;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d       = st_q;
    go_d       = 1'b0;
    edge_cnt_d = edge_cnt_q;
    err_cnt_d  = err_cnt_q;
    period_d   = period_q;
    target_d   = target_q;
    fired_d    = fired_q;
    kind_d     = kind_q;
    tmm_d      = tmm_q;
    circ_d     = circ_q;
    fact_d     = fact_q;
    rpm_d      = rpm_q;
    mmps_d     = mmps_q;
    dist_d     = dist_q;
    case (st_q)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_d  = in_i.kind;
          tmm_d   = in_i.target_mm;
          fired_d = 1'b0;
          case (in_i.kind)
            KIND_EDGE: begin
              period_d   = in_i.edge_period;
              edge_cnt_d = edge_inc;
              if (target_q != '0 && {16'd0, edge_inc} >= target_q) begin
                fired_d  = 1'b1;
                target_d = '0;
              end
            end
            KIND_ERROR: begin
              period_d  = '0;
              err_cnt_d = err_cnt_q + 32'd1;
            end
            KIND_CLEAR: begin
              edge_cnt_d = '0;
              err_cnt_d  = '0;
              period_d   = '0;
              if (target_q != '0) begin
                fired_d  = 1'b1;
                target_d = '0;
              end
            end
            default: ;
          endcase
          st_d = ST_CIRC;
          go_d = 1'b1;
        end
      end
      ST_CIRC: begin
        if (md_rsp.done) begin
          circ_d = md_rsp.quot[CIRC_W-1:0];
          go_d   = 1'b1;
          if (kind_q == KIND_ARM && tmm_q != '0 && md_rsp.quot[CIRC_W-1:0] != '0) begin
            st_d = ST_TGT;
          end else begin
            if (kind_q == KIND_ARM) begin
              // zero target disarms; no circumference: only a clear can release the target
              target_d = (tmm_q == '0) ? '0 : MAX48;
            end
            if (period_q == '0) begin
              rpm_d = '0;
              st_d  = ST_MMPS;
            end else begin
              st_d = ST_FACT;
            end
          end
        end
      end
      ST_TGT: begin
        if (md_rsp.done) begin
          target_d = (md_rsp.quot[PROD_W-1:DIST_W] != '0) ? MAX48
                                                        : md_rsp.quot[DIST_W-1:0];
          go_d = 1'b1;
          if (period_q == '0) begin
            rpm_d = '0;
            st_d  = ST_MMPS;
          end else begin
            st_d = ST_FACT;
          end
        end
      end
      ST_FACT: begin
        if (md_rsp.done) begin
          fact_d = md_rsp.quot[32:0];
          st_d   = ST_RPM;
          go_d   = 1'b1;
        end
      end
      ST_RPM: begin
        if (md_rsp.done) begin
          rpm_d = md_rsp.quot[32:0];
          st_d  = ST_MMPS;
          go_d  = 1'b1;
        end
      end
      ST_MMPS: begin
        if (md_rsp.done) begin
          mmps_d = md_rsp.quot[44:0];
          st_d   = ST_DIST;
          go_d   = 1'b1;
        end
      end
      ST_DIST: begin
        if (md_rsp.done) begin
          dist_d = (md_rsp.quot[PROD_W-1:DIST_W] != '0) ? MAX48
                                                      : md_rsp.quot[DIST_W-1:0];
          st_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      go_q        <= 1'b0;
      edge_cnt_q  <= '0;
      err_cnt_q   <= '0;
      period_q    <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      go_q        <= go_d;
      edge_cnt_q  <= edge_cnt_d;
      err_cnt_q   <= err_cnt_d;
      period_q    <= period_d;
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q <= fired_d;
    kind_q  <= kind_d;
    tmm_q   <= tmm_d;
    circ_q  <= circ_d;
    fact_q  <= fact_d;
    rpm_q   <= rpm_d;
    mmps_q  <= mmps_d;
    dist_q  <= dist_d;
    if (out_load) begin
      o_pulse_q  <= edge_cnt_q;
      o_err_q    <= err_cnt_q;
      o_period_q <= period_q;
      o_rpm_q    <= rpm_q;
      o_mmps_q   <= mmps_q;
      o_dist_q   <= dist_q;
      o_fired_q  <= fired_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pulse_count    = o_pulse_q;
  assign out_o.error_count    = o_err_q;
  assign out_o.last_period    = o_period_q;
  assign out_o.speed_rpm      = o_rpm_q;
  assign out_o.speed_mm_per_s = o_mmps_q;
  assign out_o.distance_mm    = o_dist_q;
  assign out_o.target_reached = o_fired_q;

endmodule

@@ bench/esdm_status_check.sv @@
// Status predictor and comparator for the encoder speed and distance meter bench
`timescale 1ns / 1ps

module esdm_status_check import esdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  esdm_in_if          in_i,
  esdm_out_if         out_i,
  esdm_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned released_o
);

  typedef struct packed {
    logic [31:0] pulse_count;
    logic [31:0] error_count;
    logic [15:0] last_period;
    logic [32:0] speed_rpm;
    logic [44:0] speed_mm_per_s;
    logic [47:0] distance_mm;
    logic        target_reached;
  } status_t;

  // register copies
  logic [26:0] hz   = CLOCK_HZ_RST;
  logic [15:0] ppr  = 16'd1;
  logic [7:0]  gear = 8'd1;
  logic [15:0] diam = 16'd1;

  // meter state
  logic [31:0] edge_cnt   = '0;
  logic [31:0] err_cnt    = '0;
  logic [15:0] period     = '0;
  logic [47:0] target_cnt = '0;

  status_t     status_q[$];
  status_t     want;
  int unsigned fails    = 0;
  int unsigned pending  = 0;
  int unsigned checked  = 0;
  int unsigned released = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign released_o   = released;

  // Applies one item to the meter state and returns the status it reports
  function automatic status_t meter_step(input logic [KIND_W-1:0] kind,
                                         input logic [15:0] edge_period,
                                         input logic [31:0] target_mm);
    logic [63:0] rg;
    logic [63:0] circ;
    logic [63:0] quot;
    logic [63:0] rpm;
    status_t     s;
    rg = 64'(ppr) * 64'(gear);
    if (rg == 0) rg = 64'd1;
    circ = 64'(diam) * 64'(CIRC_NUM) / 64'(CIRC_DEN);
    s.target_reached = 1'b0;
    case (kind)
      KIND_EDGE: begin
        period   = edge_period;
        edge_cnt = edge_cnt + 32'd1;
        if (target_cnt != 0 && 48'(edge_cnt) >= target_cnt) begin
          s.target_reached = 1'b1;
          target_cnt       = '0;
        end
      end
      KIND_ERROR: begin
        period  = '0;
        err_cnt = err_cnt + 32'd1;
      end
      KIND_CLEAR: begin
        edge_cnt = '0;
        err_cnt  = '0;
        period   = '0;
        if (target_cnt != 0) begin
          s.target_reached = 1'b1;
          target_cnt       = '0;
        end
      end
      KIND_ARM: begin
        if (target_mm == 0) begin
          target_cnt = '0;
        end else if (circ == 0) begin
          target_cnt = MAX48;  // nothing but a clear can release this
        end else begin
          quot       = 64'(target_mm) * rg / circ;
          target_cnt = (quot > 64'(MAX48)) ? MAX48 : quot[47:0];
        end
      end
      default: ;  // read and spare kinds leave the state alone
    endcase
    rpm = '0;
    if (period != 0) rpm = (64'(hz) * 64'(SEC_PER_MIN) / rg) / 64'(period);
    quot = 64'(edge_cnt) * circ / rg;
    s.pulse_count    = edge_cnt;
    s.error_count    = err_cnt;
    s.last_period    = period;
    s.speed_rpm      = rpm[32:0];
    s.speed_mm_per_s = 45'(rpm * circ / 64'(SEC_PER_MIN));
    s.distance_mm    = (quot > 64'(MAX48)) ? MAX48 : quot[47:0];
    return s;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      if (fails < 20)
        $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hz         = CLOCK_HZ_RST;
      ppr        = 16'd1;
      gear       = 8'd1;
      diam       = 16'd1;
      edge_cnt   = '0;
      err_cnt    = '0;
      period     = '0;
      target_cnt = '0;
      status_q.delete();
      pending    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_CLOCK_HZ:       hz   = cfg_i.data[26:0];
          REG_PULSES_PER_REV: ppr  = cfg_i.data[15:0];
          REG_GEAR_RATIO:     gear = cfg_i.data[7:0];
          REG_WHEEL_DIAM:     diam = cfg_i.data[15:0];
          default: ;
        endcase
      end
      // older results first: a result never belongs to the item taken at the same edge
      if (out_i.valid && out_i.ready) begin
        if (status_q.size() == 0) begin
          if (fails < 20) $display("%0d ns: status transfer with nothing expected", $time);
          fails++;
        end else begin
          want = status_q.pop_front();
          compare_field("pulse_count", 64'(want.pulse_count), 64'(out_i.pulse_count));
          compare_field("error_count", 64'(want.error_count), 64'(out_i.error_count));
          compare_field("last_period", 64'(want.last_period), 64'(out_i.last_period));
          compare_field("speed_rpm", 64'(want.speed_rpm), 64'(out_i.speed_rpm));
          compare_field("speed_mm_per_s", 64'(want.speed_mm_per_s),
                        64'(out_i.speed_mm_per_s));
          compare_field("distance_mm", 64'(want.distance_mm), 64'(out_i.distance_mm));
          compare_field("target_reached", 64'(want.target_reached),
                        64'(out_i.target_reached));
          checked++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        want = meter_step(in_i.kind, in_i.edge_period, in_i.target_mm);
        status_q.push_back(want);
        if (want.target_reached) released++;
      end
      pending = status_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Top of the encoder speed and distance meter bench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module tb;
  import esdm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_READ        = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  // no register behind this index
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hA5;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  esdm_in_if  in_if ();
  esdm_out_if out_if ();
  esdm_cfg_if cfg_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned released;

  // register values last written, used to aim targets within reach
  logic [15:0] cur_ppr  = 16'd1;
  logic [7:0]  cur_gear = 8'd1;
  logic [15:0] cur_diam = 16'd1;

  int unsigned items_sent = 0;
  int unsigned settings   = 0;
  bit          steady_in  = 1'b0;

  always #10 clk_i = ~clk_i;

  encoder_speed_distance_meter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  esdm_status_check status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .released_o   (released)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 18) return 16'hFFFF;
    if (r < 50) return 16'($urandom_range(1, 255));
    return 16'($urandom());
  endfunction

  // target distance that lands roughly on the given edge count
  function automatic logic [31:0] target_for(input int unsigned count);
    logic [63:0] rg;
    logic [63:0] circ;
    logic [63:0] mm;
    rg = 64'(cur_ppr) * 64'(cur_gear);
    if (rg == 0) rg = 64'd1;
    circ = 64'(cur_diam) * 64'(CIRC_NUM) / 64'(CIRC_DEN);
    mm = (64'(count) * circ + rg - 1) / rg;
    if (mm > 64'hFFFF_FFFF) mm = 64'hFFFF_FFFF;
    if (mm == 0) mm = 64'd1;
    return mm[31:0];
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [15:0] period,
                           input logic [31:0] tmm);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.kind        <= kind;
    in_if.edge_period <= period;
    in_if.target_mm   <= tmm;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // valid stays high between back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [26:0] hz, input logic [15:0] ppr,
                                input logic [7:0] gear, input logic [15:0] diam);
    wait_idle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    write_reg(REG_CLOCK_HZ, hz);
    // unused upper bits carry junk
    write_reg(REG_PULSES_PER_REV, {11'($urandom()), ppr});
    write_reg(REG_GEAR_RATIO, {19'($urandom()), gear});
    write_reg(REG_WHEEL_DIAM, {11'($urandom()), diam});
    cfg_if.valid <= 1'b0;
    cur_ppr  = ppr;
    cur_gear = gear;
    cur_diam = diam;
    settings++;
  endtask

  // optional clear, an arm, then a run of mostly edges
  task automatic run_sequence();
    int n;
    int r;
    steady_in = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) == 0) send_item(KIND_CLEAR, 16'($urandom()), $urandom());
    r = $urandom_range(0, 99);
    if (r < 80)
      send_item(KIND_ARM, 16'($urandom()), target_for($urandom_range(1, 12)));
    else if (r < 90)
      send_item(KIND_ARM, 16'($urandom()), $urandom());
    else
      send_item(KIND_ARM, 16'($urandom()), 32'd0);
    n = $urandom_range(3, 16);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        send_item(KIND_EDGE, pick_period(), $urandom());
      else if (r < 80)
        send_item(KIND_ERROR, 16'($urandom()), $urandom());
      else if (r < 88)
        send_item(KIND_READ, 16'($urandom()), $urandom());
      else if (r < 92)
        send_item(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                  16'($urandom()), $urandom());
      else if (r < 96)
        send_item(KIND_ARM, 16'($urandom()), target_for($urandom_range(0, 8)));
      else
        send_item(KIND_CLEAR, 16'($urandom()), $urandom());
    end
  endtask

  // status sink
  initial begin
    int          stall;
    int unsigned taken;
    bit          steady_out;
    taken      = 0;
    steady_out = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // long hold-off so the meter backs up and stalls its input
      if (taken == 300 || taken == 1100)
        stall = 2500;
      else
        stall = steady_out ? 0 : pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (!out_if.valid);
      @(posedge clk_i);
      taken++;
      if (taken % 50 == 0) steady_out = ($urandom_range(0, 3) == 0);
    end
  end

  // stimulus and verdict
  initial begin
    logic [26:0] hz;
    logic [15:0] ppr;
    logic [7:0]  gear;
    logic [15:0] diam;
    int          r;
    in_if.valid       <= 1'b0;
    in_if.kind        <= '0;
    in_if.edge_period <= '0;
    in_if.target_mm   <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults
    send_item(KIND_READ, 16'($urandom()), $urandom());
    send_item(KIND_EDGE, 16'd0, 32'd0);
    send_item(KIND_EDGE, 16'd1, 32'd0);
    send_item(KIND_EDGE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(KIND_ERROR, 16'($urandom()), $urandom());
    send_item(KIND_ARM, 16'd0, 32'd7);           // already passed, fires on next edge
    send_item(KIND_EDGE, 16'h5555, 32'd0);
    send_item(KIND_ARM, 16'd0, 32'hFFFF_FFFF);
    send_item(KIND_CLEAR, 16'd0, 32'd0);         // releases the armed target
    send_item(KIND_ARM, 16'd0, 32'd0);
    send_item(KIND_CLEAR, 16'd0, 32'd0);
    send_item(KIND_SPARE_FIRST, 16'($urandom()), $urandom());
    send_item(KIND_SPARE_LAST, 16'($urandom()), $urandom());
    send_item(KIND_EDGE, 16'hAAAA, 32'h5555_5555);

    // fastest timer, unit resolution, largest wheel
    apply_settings(27'd100000000, 16'd1, 8'd1, 16'hFFFF);
    send_item(KIND_EDGE, 16'd1, 32'd0);
    send_item(KIND_ARM, 16'd0, 32'd411558);
    send_item(KIND_EDGE, 16'd2, 32'd0);
    send_item(KIND_ARM, 16'd0, 32'hFFFF_FFFF);

    // slowest timer, finest resolution, smallest wheel: target saturates
    apply_settings(27'd1, 16'hFFFF, 8'hFF, 16'd1);
    send_item(KIND_ARM, 16'd0, 32'hFFFF_FFFF);
    send_item(KIND_EDGE, 16'd1, 32'd0);
    send_item(KIND_CLEAR, 16'd0, 32'd0);

    // zero resolution, gear and diameter
    apply_settings(27'd100000000, 16'd0, 8'd0, 16'd0);
    send_item(KIND_EDGE, 16'd3, 32'd0);
    send_item(KIND_ARM, 16'd0, 32'd5);
    send_item(KIND_EDGE, 16'd4, 32'd0);
    send_item(KIND_CLEAR, 16'd0, 32'd0);
    send_item(KIND_ARM, 16'd0, 32'd0);

    for (int p = 0; p < 8; p++) begin
      r    = $urandom_range(0, 99);
      hz   = (r < 10) ? 27'h7FF_FFFF : (r < 15) ? 27'd0 : (r < 20) ? 27'd1 :
             27'($urandom_range(1, 100000000));
      r    = $urandom_range(0, 99);
      ppr  = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : (r < 70) ?
             16'($urandom_range(1, 64)) : 16'($urandom_range(1, 65535));
      r    = $urandom_range(0, 99);
      gear = (r < 5) ? 8'd0 : (r < 10) ? 8'hFF : (r < 70) ?
             8'($urandom_range(1, 8)) : 8'($urandom_range(1, 255));
      r    = $urandom_range(0, 99);
      diam = (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      apply_settings(hz, ppr, gear, diam);
      while (items_sent < 26 + (p + 1) * 205) run_sequence();
    end

    wait_idle();
    repeat (600) @(posedge clk_i);
    $display("Sent %0d items under %0d register settings after the defaults;", items_sent,
             settings);
    $display("checked %0d status results, %0d of them releasing a target.", checked,
             released);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/esdm_pkg.sv
rtl/esdm_if.sv
rtl/esdm_cfg_regs.sv
rtl/esdm_muldiv.sv
rtl/encoder_speed_distance_meter.sv
bench/esdm_status_check.sv
bench/tb.sv
